>>> rtl/core/pvp_pkg.sv
// ----------------------------------------------------------------------------
// pvp_pkg
// Shared types, widths and constants for the perspective vertex projector.
// ----------------------------------------------------------------------------
package pvp_pkg;

  localparam int DATA_W        = 32;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int QUO_W         = DATA_W;
  localparam int N_LANES       = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 2;

  localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_SCALE  = 2'd0,
    CFG_Y_SCALE  = 2'd1,
    CFG_Z_SCALE  = 2'd2,
    CFG_Z_OFFSET = 2'd3
  } cfg_reg_t;

  // One item as it travels along the divider chain.
  typedef struct packed {
    logic                           valid;
    logic                           w_zero;
    logic [DATA_W-1:0]              divisor;
    logic [N_LANES-1:0]             neg;
    logic [N_LANES-1:0][PROD_W-1:0] rem;
    logic [N_LANES-1:0][QUO_W-1:0]  quo;
  } cell_data_t;

  function automatic logic signed [PROD_W-1:0] sext(input logic [DATA_W-1:0] v);
    sext = {{(PROD_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

endpackage

>>> rtl/core/pvp_front.sv
// ----------------------------------------------------------------------------
// pvp_front
// Scales the vertex, adds the depth offset and splits each numerator into
// sign and magnitude together with the divisor, over three register stages.
// ----------------------------------------------------------------------------
module pvp_front #(
  parameter int FRAC_BITS = pvp_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_take,
  input  logic [pvp_pkg::DATA_W-1:0] vert_x,
  input  logic [pvp_pkg::DATA_W-1:0] vert_y,
  input  logic [pvp_pkg::DATA_W-1:0] vert_z,
  input  logic [pvp_pkg::DATA_W-1:0] x_scale,
  input  logic [pvp_pkg::DATA_W-1:0] y_scale,
  input  logic [pvp_pkg::DATA_W-1:0] z_scale,
  input  logic [pvp_pkg::DATA_W-1:0] z_offset,
  output pvp_pkg::cell_data_t        d_out
);
  import pvp_pkg::*;

  logic                                 va_r, vb_r;
  logic signed [N_LANES-1:0][PROD_W-1:0] prod_r;
  logic signed [N_LANES-1:0][PROD_W-1:0] num_r;
  logic        [DATA_W-1:0]            za_r, zb_r;
  logic signed [PROD_W-1:0]            zsum;
  logic signed [PROD_W-1:0]            off_al;
  cell_data_t                          d_nxt, d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r    <= 1'b0;
      vb_r    <= 1'b0;
      d_r.valid <= 1'b0;
    end else begin
      va_r    <= in_take;
      vb_r    <= va_r;
      d_r.valid <= d_nxt.valid;
    end
    prod_r[0]  <= sext(vert_x) * sext(x_scale);
    prod_r[1]  <= sext(vert_y) * sext(y_scale);
    prod_r[2]  <= sext(vert_z) * sext(z_scale);
    za_r       <= vert_z;
    num_r[0]   <= prod_r[0];
    num_r[1]   <= prod_r[1];
    num_r[2]   <= zsum;
    zb_r       <= za_r;
    d_r.w_zero  <= d_nxt.w_zero;
    d_r.divisor <= d_nxt.divisor;
    d_r.neg     <= d_nxt.neg;
    d_r.rem     <= d_nxt.rem;
    d_r.quo     <= d_nxt.quo;
  end

  assign off_al = sext(z_offset) <<< FRAC_BITS;
  assign zsum   = prod_r[2] + off_al;

  always_comb begin
    d_nxt.valid  = vb_r;
    d_nxt.w_zero = (zb_r == '0);
    // A zero w divides by one in fixed point, which is the plain shift down.
    if (d_nxt.w_zero) begin
      d_nxt.divisor = DATA_W'(1) << FRAC_BITS;
    end else if (zb_r[DATA_W-1]) begin
      d_nxt.divisor = DATA_W'(0) - zb_r;
    end else begin
      d_nxt.divisor = zb_r;
    end
    for (int i = 0; i < N_LANES; i++) begin
      d_nxt.neg[i] = num_r[i][PROD_W-1] ^ (zb_r[DATA_W-1] & ~d_nxt.w_zero);
      d_nxt.rem[i] = num_r[i][PROD_W-1] ? PROD_W'(0) - num_r[i] : num_r[i];
      d_nxt.quo[i] = '0;
    end
  end

  assign d_out = d_r;

endmodule

>>> rtl/core/pvp_div_cell.sv
// ----------------------------------------------------------------------------
// pvp_div_cell
// One step of the restoring divider: decides quotient bit SHIFT for all three
// lanes and hands the reduced remainders to the next cell.
// ----------------------------------------------------------------------------
module pvp_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pvp_pkg::cell_data_t d_in,
  output pvp_pkg::cell_data_t d_out
);
  import pvp_pkg::*;

  localparam logic [QUO_W-1:0] LOW_MASK = (QUO_W'(1) << SHIFT) - QUO_W'(1);

  logic [PROD_W-1:0] step;
  logic [PROD_W:0]   diff [N_LANES];
  cell_data_t        d_nxt, d_r;

  assign step = PROD_W'(d_in.divisor) << SHIFT;

  always_comb begin
    d_nxt = d_in;
    for (int i = 0; i < N_LANES; i++) begin
      diff[i] = {1'b0, d_in.rem[i]} - {1'b0, step};
      if (!diff[i][PROD_W]) begin
        d_nxt.rem[i]        = diff[i][PROD_W-1:0];
        d_nxt.quo[i][SHIFT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else begin
      d_r.valid <= d_nxt.valid;
    end
    d_r.w_zero  <= d_nxt.w_zero;
    d_r.divisor <= d_nxt.divisor;
    d_r.neg     <= d_nxt.neg;
    d_r.rem     <= d_nxt.rem;
    d_r.quo     <= d_nxt.quo;
  end

  assign d_out = d_r;

`ifndef SYNTH
  a_valid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    d_in.valid |=> d_r.valid)
    else $error("item lost in divider cell");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    d_r.valid |-> d_r.divisor != '0)
    else $error("zero divisor in divider chain");

  a_low_bits_clear: assert property (@(posedge clk) disable iff (!rst_n)
    d_r.valid |-> ((d_r.quo[0] & LOW_MASK) == '0) && ((d_r.quo[1] & LOW_MASK) == '0)
                  && ((d_r.quo[2] & LOW_MASK) == '0))
    else $error("quotient bit set ahead of its cell");
`endif

endmodule

>>> rtl/core/perspective_vertex_project_core.sv
// ----------------------------------------------------------------------------
// perspective_vertex_project_core
// Perspective projection of one Q-format vertex per cycle with divide by w.
// ----------------------------------------------------------------------------
// A vertex is taken on every cycle in which start is high; busy stays low, so
// the block takes one item per clock with no gaps. Each item leaves on the
// out_ ports, marked by out_valid for one cycle, after it has been scaled,
// offset and split into sign and magnitude in the front registers, passed
// through a chain of divider cells that each settle one quotient bit for x,
// y and z at once, and saturated in the output register. Items
// come out in the order they went in. The cfg_ port is always ready;
// registers should be written only while no item is in flight.
// ----------------------------------------------------------------------------
module perspective_vertex_project_core #(
  parameter int FRAC_BITS = pvp_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [pvp_pkg::DATA_W-1:0]    in_vert_x,
  input  logic [pvp_pkg::DATA_W-1:0]    in_vert_y,
  input  logic [pvp_pkg::DATA_W-1:0]    in_vert_z,
  output logic                          out_valid,
  output logic [pvp_pkg::DATA_W-1:0]    out_proj_x,
  output logic [pvp_pkg::DATA_W-1:0]    out_proj_y,
  output logic [pvp_pkg::DATA_W-1:0]    out_proj_z,
  output logic                          out_w_was_zero,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pvp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pvp_pkg::DATA_W-1:0]    cfg_data
);
  import pvp_pkg::*;

  localparam int N_CELLS = QUO_W;

  logic [DATA_W-1:0] x_scale_r, y_scale_r, z_scale_r, z_offset_r;
  logic              in_take;
  cell_data_t        chain [N_CELLS+1];
  cell_data_t        tail;
  logic [N_LANES-1:0][DATA_W-1:0] res_nxt, res_r;
  logic              out_valid_r;
  logic              wz_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_take   = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_scale_r  <= DATA_W'(1) << FRAC_BITS;
      y_scale_r  <= DATA_W'(1) << FRAC_BITS;
      z_scale_r  <= DATA_W'(1) << FRAC_BITS;
      z_offset_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_X_SCALE:  x_scale_r  <= cfg_data;
        CFG_Y_SCALE:  y_scale_r  <= cfg_data;
        CFG_Z_SCALE:  z_scale_r  <= cfg_data;
        CFG_Z_OFFSET: z_offset_r <= cfg_data;
      endcase
    end
  end

  pvp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (in_take),
    .vert_x   (in_vert_x),
    .vert_y   (in_vert_y),
    .vert_z   (in_vert_z),
    .x_scale  (x_scale_r),
    .y_scale  (y_scale_r),
    .z_scale  (z_scale_r),
    .z_offset (z_offset_r),
    .d_out    (chain[0])
  );

  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    pvp_div_cell #(.SHIFT(N_CELLS - 1 - g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (chain[g]),
      .d_out (chain[g+1])
    );
  end

  assign tail = chain[N_CELLS];

  // The top quotient bit set means the magnitude reached the saturation range.
  always_comb begin
    for (int i = 0; i < N_LANES; i++) begin
      if (tail.quo[i][QUO_W-1]) begin
        res_nxt[i] = tail.neg[i] ? SAT_NEG : SAT_POS;
      end else if (tail.neg[i]) begin
        res_nxt[i] = DATA_W'(0) - tail.quo[i];
      end else begin
        res_nxt[i] = tail.quo[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tail.valid;
    end
    res_r <= res_nxt;
    wz_r  <= tail.w_zero;
  end

  assign out_valid      = out_valid_r;
  assign out_proj_x     = res_r[0];
  assign out_proj_y     = res_r[1];
  assign out_proj_z     = res_r[2];
  assign out_w_was_zero = wz_r;

`ifndef SYNTH
  a_tail_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |=> out_valid)
    else $error("item dropped at output stage");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    !tail.valid |=> !out_valid)
    else $error("result without item");

  a_zero_w_div: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid && tail.w_zero |-> tail.divisor == (DATA_W'(1) << FRAC_BITS))
    else $error("zero w item carries wrong divisor");
`endif

endmodule

>>> dv/perspective_vertex_project_core_test.sv
// ----------------------------------------------------------------------------
// perspective_vertex_project_core_test
// Self-checking bench for the perspective vertex projector. Vertices go in
// through the start/busy handshake, with random gaps in some phases. A
// scoreboard keeps its own copy of the four projection coefficients and
// works out the projected x, y and z and the zero-w flag for every accepted
// vertex. It compares each out_valid strobe against the oldest expectation.
// The coefficients are reloaded between phases, extreme values among them.
// ----------------------------------------------------------------------------
module perspective_vertex_project_core_test;

  import pvp_pkg::*;

  localparam int FRAC_BITS = FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 175;
  localparam int N_PHASES = 9;

  localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [DATA_W-1:0] Q_MAX = SAT_POS;
  localparam logic [DATA_W-1:0] Q_MIN = SAT_NEG;

  typedef struct packed {
    logic [DATA_W-1:0] proj_x;
    logic [DATA_W-1:0] proj_y;
    logic [DATA_W-1:0] proj_z;
    logic              w_was_zero;
  } proj_result_t;

  class projection_scoreboard;
    logic [DATA_W-1:0] x_scale;
    logic [DATA_W-1:0] y_scale;
    logic [DATA_W-1:0] z_scale;
    logic [DATA_W-1:0] z_offset;
    proj_result_t      expected_q[$];
    int                mismatches;
    int                checked;
    int                vertices;
    int                zero_w;

    function new();
      x_scale    = Q_ONE;
      y_scale    = Q_ONE;
      z_scale    = Q_ONE;
      z_offset   = '0;
      mismatches = 0;
      checked    = 0;
      vertices   = 0;
      zero_w     = 0;
    endfunction

    function void load_coef(cfg_reg_t idx, logic [DATA_W-1:0] value);
      case (idx)
        CFG_X_SCALE:  x_scale  = value;
        CFG_Y_SCALE:  y_scale  = value;
        CFG_Z_SCALE:  z_scale  = value;
        CFG_Z_OFFSET: z_offset = value;
        default: ;
      endcase
    endfunction

    // The numerator carries twice the fraction bits, w carries them once.
    function logic [DATA_W-1:0] divide_by_w(longint num, longint w);
      logic [63:0] mag;
      logic [63:0] wmag;
      logic [63:0] q;
      bit          neg;
      mag = (num < 0) ? -num : num;
      neg = (num < 0);
      if (w == 0) begin
        q = mag >> FRAC_BITS;
      end else begin
        wmag = (w < 0) ? -w : w;
        if (w < 0) begin
          neg = !neg;
        end
        q = mag / wmag;
        neg = neg && (mag != 0);
      end
      if (neg) begin
        if (q > 64'h8000_0000) begin
          q = 64'h8000_0000;
        end
        q = -q;
      end else if (q > 64'h7FFF_FFFF) begin
        q = 64'h7FFF_FFFF;
      end
      return q[DATA_W-1:0];
    endfunction

    function void note_vertex(logic [DATA_W-1:0] vx, logic [DATA_W-1:0] vy,
                              logic [DATA_W-1:0] vz);
      longint       x;
      longint       y;
      longint       z;
      longint       nz;
      proj_result_t r;
      x  = longint'($signed(vx));
      y  = longint'($signed(vy));
      z  = longint'($signed(vz));
      nz = z * longint'($signed(z_scale)) + longint'($signed(z_offset)) * (64'sd1 <<< FRAC_BITS);
      r.proj_x     = divide_by_w(x * longint'($signed(x_scale)), z);
      r.proj_y     = divide_by_w(y * longint'($signed(y_scale)), z);
      r.proj_z     = divide_by_w(nz, z);
      r.w_was_zero = (z == 0);
      expected_q.insert(expected_q.size(), r);
      vertices++;
      if (z == 0) begin
        zero_w++;
      end
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] exp_v,
                                logic [DATA_W-1:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_result(logic [DATA_W-1:0] px, logic [DATA_W-1:0] py,
                               logic [DATA_W-1:0] pz, logic wz);
      proj_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no vertex pending, expected none actual %h %h %h %b",
                 $time, px, py, pz, wz);
        mismatches++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      compare_field("proj_x", exp_r.proj_x, px);
      compare_field("proj_y", exp_r.proj_y, py);
      compare_field("proj_z", exp_r.proj_z, pz);
      compare_field("w_was_zero", {31'd0, exp_r.w_was_zero}, {31'd0, wz});
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [DATA_W-1:0] in_vert_x = '0;
  logic [DATA_W-1:0] in_vert_y = '0;
  logic [DATA_W-1:0] in_vert_z = '0;
  logic              out_valid;
  logic [DATA_W-1:0] out_proj_x;
  logic [DATA_W-1:0] out_proj_y;
  logic [DATA_W-1:0] out_proj_z;
  logic              out_w_was_zero;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  projection_scoreboard sb;
  int sender_idle_pct = 0;
  int coef_sets = 1;
  int stall_cycles = 0;

  perspective_vertex_project_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_vert_x      (in_vert_x),
    .in_vert_y      (in_vert_y),
    .in_vert_z      (in_vert_z),
    .out_valid      (out_valid),
    .out_proj_x     (out_proj_x),
    .out_proj_y     (out_proj_y),
    .out_proj_z     (out_proj_z),
    .out_w_was_zero (out_w_was_zero),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_proj_x, out_proj_y, out_proj_z, out_w_was_zero);
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid || (cfg_valid && cfg_ready))) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, stall_cycles, sb.pending());
        $display("perspective_vertex_project_core regression: fail");
        $finish;
      end
    end
  end

  // Mostly mid-range values of every magnitude, with some full-range words and extremes.
  function automatic logic [DATA_W-1:0] rand_word();
    logic [DATA_W-1:0] v;
    int                sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1: begin
        v = $urandom;
      end
      2: begin
        case ($urandom_range(4))
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = '0;
          3: v = 32'd1;
          default: v = '1;
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(31);
        if ($urandom_range(1) == 1) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  task automatic send_vertex(logic [DATA_W-1:0] vx, logic [DATA_W-1:0] vy,
                             logic [DATA_W-1:0] vz);
    while ($urandom_range(99) < sender_idle_pct) begin
      start     <= 1'b0;
      in_vert_x <= $urandom;
      in_vert_y <= $urandom;
      in_vert_z <= $urandom;
      @(posedge clk);
    end
    start     <= 1'b1;
    in_vert_x <= vx;
    in_vert_y <= vy;
    in_vert_z <= vz;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    sb.note_vertex(vx, vy, vz);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_one(cfg_reg_t idx, logic [DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(posedge clk);
    end while (cfg_ready !== 1'b1);
    sb.load_coef(idx, value);
  endtask

  task automatic write_coefs(logic [DATA_W-1:0] xs, logic [DATA_W-1:0] ys,
                             logic [DATA_W-1:0] zs, logic [DATA_W-1:0] zo);
    write_one(CFG_X_SCALE, xs);
    write_one(CFG_Y_SCALE, ys);
    write_one(CFG_Z_SCALE, zs);
    write_one(CFG_Z_OFFSET, zo);
    cfg_valid <= 1'b0;
    coef_sets++;
  endtask

  task automatic load_phase_coefs(int phase);
    case (phase)
      0: write_coefs(32'h0001_8000, 32'h0001_BB67, 32'h0001_0A3D, 32'hFFFF_E5C3);
      1: write_coefs(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      2: write_coefs(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      3: write_coefs('0, '0, '0, '0);
      4: write_coefs(Q_MIN, Q_MAX, '0, Q_MAX);
      5: write_coefs(-Q_ONE, Q_ONE, Q_MAX, Q_MIN);
      default: write_coefs(rand_word(), rand_word(), rand_word(), rand_word());
    endcase
  endtask

  task automatic run_random(int count);
    logic [DATA_W-1:0] vz;
    for (int i = 0; i < count; i++) begin
      vz = ($urandom_range(9) == 0) ? '0 : rand_word();
      send_vertex(rand_word(), rand_word(), vz);
    end
  endtask

  task automatic run_directed();
    send_vertex('0, '0, '0);
    send_vertex(Q_ONE, Q_ONE, Q_ONE);
    send_vertex(Q_MAX, Q_MIN, Q_ONE);
    send_vertex(Q_MIN, Q_MAX, -Q_ONE);
    send_vertex(Q_MAX, Q_MAX, '0);
    send_vertex(Q_MIN, Q_MIN, '0);
    send_vertex(Q_ONE, -Q_ONE, 32'd1);
    send_vertex(-Q_ONE, Q_ONE, '1);
    send_vertex('0, '0, -Q_ONE);
    send_vertex(Q_MAX, Q_MIN, Q_MAX);
    send_vertex(Q_MIN, Q_MAX, Q_MIN);
    send_vertex(Q_ONE, -Q_ONE, 32'd3);
    send_vertex(32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000);
    send_vertex('1, 32'd1, '0);
    send_vertex(32'h0000_7FFF, 32'hFFFF_8001, '0);
    send_vertex(32'h1234_5678, 32'hEDCB_A988, 32'hFFFE_0000);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // The reset coefficients are checked first, with the sender never idle.
    run_directed();
    wait_drained();
    for (int p = 0; p < N_PHASES; p++) begin
      sender_idle_pct = (p < 3) ? 19 : (p < 6) ? 51 : 0;
      load_phase_coefs(p);
      run_random(PHASE_ITEMS);
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Projected %0d vertices (%0d with w zero) under %0d coefficient sets.",
             sb.vertices, sb.zero_w, coef_sets);
    $display("Checked %0d results, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("perspective_vertex_project_core regression: pass");
    end else begin
      $display("perspective_vertex_project_core regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/pvp_pkg.sv
rtl/core/pvp_front.sv
rtl/core/pvp_div_cell.sv
rtl/core/perspective_vertex_project_core.sv
dv/perspective_vertex_project_core_test.sv
